// File: design/izhikevich_neuron_step_top_assert.svh
// ---------------------------------------------------------------------------
// izhikevich neuron step assertion macros
// concurrent assertion shorthands used by the top design file
// ---------------------------------------------------------------------------
`ifndef IZHIKEVICH_NEURON_STEP_TOP_ASSERT_SVH
`define IZHIKEVICH_NEURON_STEP_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IZN_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define IZN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/izn_pkg.sv
// ---------------------------------------------------------------------------
// izhikevich neuron step package
// fixed point constants, value types, codes and the saturation function
// ---------------------------------------------------------------------------
package izn_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = 25;
   localparam int SUM_W     = 32;

   // shared multiplier geometry
   localparam int MUL_W   = 30;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SHIFT_W = PROD_W - FRAC_BITS;

   typedef logic signed [FIELD_W-1:0] neuron_value_type;
   typedef logic signed [SUM_W-1:0]   wide_sum_type;
   typedef logic signed [MUL_W-1:0]   mul_op_type;
   typedef logic signed [PROD_W-1:0]  mul_prod_type;

   // model constants
   localparam wide_sum_type SAT_LIM = wide_sum_type'(200 << FRAC_BITS);
   localparam wide_sum_type C140    = wide_sum_type'(140 << FRAC_BITS);
   localparam mul_op_type   K004    = mul_op_type'(((4 << FRAC_BITS) + 50) / 100);

   // register reset values
   localparam logic [16:0]        A_RESET  = 17'(((2 << FRAC_BITS) + 50) / 100);
   localparam logic [16:0]        B_RESET  = 17'(((20 << FRAC_BITS) + 50) / 100);
   localparam logic signed [23:0] C_RESET  = 24'(-(65 << FRAC_BITS));
   localparam logic [20:0]        D_RESET  = 21'(8 << FRAC_BITS);
   localparam logic [21:0]        TH_RESET = 22'(20 << FRAC_BITS);

   // neuron state reset values
   localparam neuron_value_type V_RESET = neuron_value_type'(-(65 << FRAC_BITS));
   localparam neuron_value_type U_RESET = neuron_value_type'(-(13 << FRAC_BITS));

   // item modes
   localparam logic [1:0] MODE_INTEGRATE = 2'd0;
   localparam logic [1:0] MODE_FIRE      = 2'd1;
   localparam logic [1:0] MODE_SET       = 2'd2;
   localparam logic [1:0] MODE_ADD       = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_PARAM_A         = 3'd0;
   localparam logic [2:0] CSR_PARAM_B         = 3'd1;
   localparam logic [2:0] CSR_PARAM_C         = 3'd2;
   localparam logic [2:0] CSR_PARAM_D         = 3'd3;
   localparam logic [2:0] CSR_SPIKE_THRESHOLD = 3'd4;

   // clamp a wide sum to +-200
   function automatic neuron_value_type sat_value(input wide_sum_type x);
      neuron_value_type r;
      if (x > SAT_LIM) begin
         r = neuron_value_type'(SAT_LIM);
      end else if (x < -SAT_LIM) begin
         r = neuron_value_type'(-SAT_LIM);
      end else begin
         r = neuron_value_type'(x);
      end
      return r;
   endfunction

endpackage

// File: design/izhikevich_neuron_step_top.sv
// ---------------------------------------------------------------------------
// izhikevich neuron step
// one izhikevich neuron in fixed point, sequenced over a shared multiplier
// ---------------------------------------------------------------------------
// integrate items run nine products in turn on the one shared 30x30
// multiplier before the result is registered; firing and current items
// go straight to the result register. A new item is taken only when idle,
// so not before the previous result has been loaded into the result register
// reset: synchronous, active high; parameters return to their defaults and
// the neuron to v = -65, u = -13, current 0, no spike
module izhikevich_neuron_step_top (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // step_ms[18:0], current_value[42:19], zero fill
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // out_voltage[24:0], out_recovery[49:25],
                                    // out_current[74:50], fired[75], zero fill
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import izn_pkg::*;

`include "izhikevich_neuron_step_top_assert.svh"

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL_KV = 4'd1;
   localparam logic [3:0] ST_MUL_SQ = 4'd2;
   localparam logic [3:0] ST_DERIV  = 4'd3;
   localparam logic [3:0] ST_MUL_H  = 4'd4;
   localparam logic [3:0] ST_UPD_V  = 4'd5;
   localparam logic [3:0] ST_MUL_BV = 4'd6;
   localparam logic [3:0] ST_MUL_DA = 4'd7;
   localparam logic [3:0] ST_MUL_RU = 4'd8;
   localparam logic [3:0] ST_UPD_U  = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   // configuration registers
   logic [16:0]        a_ff, a_in;
   logic [16:0]        b_ff, b_in;
   logic signed [23:0] c_ff, c_in;
   logic [20:0]        d_ff, d_in;
   logic [21:0]        th_ff, th_in;

   // neuron state
   neuron_value_type   v_ff, v_in;
   neuron_value_type   u_ff, u_in;
   neuron_value_type   i_ff, i_in;
   logic               spike_ff, spike_in;

   // sequencer and working registers
   logic [3:0]         state_ff, state_in;
   logic               second_ff, second_in;
   logic [18:0]        dt_ff, dt_in;
   mul_op_type         deriv_ff, deriv_in;
   mul_op_type         diff_ff, diff_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic               mul_en;
   mul_op_type         op_a;
   mul_op_type         op_b;
   mul_prod_type       prod;
   logic signed [SHIFT_W-1:0] prod_sh;

   // unpacked input fields
   logic [1:0]         in_mode;
   logic [18:0]        in_step;
   logic signed [23:0] in_cv;
   logic               req_accept;
   logic               rsp_load;

   wide_sum_type       v32;
   wide_sum_type       u32;
   wide_sum_type       i32;
   wide_sum_type       prod_sum;

   assign in_mode    = req_tuser;
   assign in_step    = req_tdata[18:0];
   assign in_cv      = $signed(req_tdata[42:19]);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign v32      = wide_sum_type'(v_ff);
   assign u32      = wide_sum_type'(u_ff);
   assign i32      = wide_sum_type'(i_ff);
   assign prod_sh  = SHIFT_W'(prod >>> FRAC_BITS);
   assign prod_sum = wide_sum_type'(prod_sh);

   izn_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod)
   );

   // operand selection for the shared multiplier
   always_comb begin
      mul_en = 1'b1;
      op_a   = '0;
      op_b   = '0;
      unique case (state_ff)
         ST_MUL_KV: begin
            op_a = K004;
            op_b = mul_op_type'(v_ff);
         end
         ST_MUL_SQ: begin
            op_a = mul_op_type'(prod_sh);
            op_b = mul_op_type'(v_ff);
         end
         ST_MUL_H: begin
            op_a = mul_op_type'($signed({1'b0, dt_ff[18:1]}));
            op_b = deriv_ff;
         end
         ST_MUL_BV: begin
            op_a = mul_op_type'($signed({1'b0, b_ff}));
            op_b = mul_op_type'(v_ff);
         end
         ST_MUL_DA: begin
            op_a = mul_op_type'($signed({1'b0, dt_ff}));
            op_b = mul_op_type'($signed({1'b0, a_ff}));
         end
         ST_MUL_RU: begin
            op_a = mul_op_type'(prod_sh);
            op_b = diff_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      a_in  = a_ff;
      b_in  = b_ff;
      c_in  = c_ff;
      d_in  = d_ff;
      th_in = th_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_PARAM_A:         a_in  = csr_data[16:0];
            CSR_PARAM_B:         b_in  = csr_data[16:0];
            CSR_PARAM_C:         c_in  = $signed(csr_data);
            CSR_PARAM_D:         d_in  = csr_data[20:0];
            CSR_SPIKE_THRESHOLD: th_in = csr_data[21:0];
            default: ;
         endcase
      end
   end

   // sequencer and neuron state update
   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      dt_in     = dt_ff;
      deriv_in  = deriv_ff;
      diff_in   = diff_ff;
      v_in      = v_ff;
      u_in      = u_ff;
      i_in      = i_ff;
      spike_in  = spike_ff;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dt_in     = in_step;
               second_in = 1'b0;
               state_in  = ST_DONE;
               case (in_mode)
                  MODE_INTEGRATE: begin
                     state_in = ST_MUL_KV;
                  end
                  MODE_FIRE: begin
                     if (v32 > $signed({10'b0, th_ff})) begin
                        spike_in = 1'b1;
                        v_in     = sat_value(wide_sum_type'(c_ff));
                        u_in     = sat_value(u32 + $signed({11'b0, d_ff}));
                     end else begin
                        spike_in = 1'b0;
                     end
                  end
                  MODE_SET: begin
                     i_in = sat_value(wide_sum_type'(in_cv));
                  end
                  default: begin
                     i_in = sat_value(i32 + wide_sum_type'(in_cv));
                  end
               endcase
            end
         end
         ST_MUL_KV: state_in = ST_MUL_SQ;
         ST_MUL_SQ: state_in = ST_DERIV;
         ST_DERIV: begin
            // 0.04 v^2 + 5 v + 140 - u + I
            deriv_in = mul_op_type'(prod_sum + (v32 <<< 2) + v32 + C140 - u32 + i32);
            state_in = ST_MUL_H;
         end
         ST_MUL_H: state_in = ST_UPD_V;
         ST_UPD_V: begin
            v_in = sat_value(v32 + prod_sum);
            if (second_ff) begin
               second_in = 1'b0;
               state_in  = ST_MUL_BV;
            end else begin
               second_in = 1'b1;
               state_in  = ST_MUL_KV;
            end
         end
         ST_MUL_BV: state_in = ST_MUL_DA;
         ST_MUL_DA: begin
            // b v - u, from the product of the previous cycle
            diff_in  = mul_op_type'(prod_sum - u32);
            state_in = ST_MUL_RU;
         end
         ST_MUL_RU: state_in = ST_UPD_U;
         ST_UPD_U: begin
            u_in     = sat_value(u32 + prod_sum);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register next value
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = {4'b0, spike_ff, i_ff, u_ff, v_ff};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= A_RESET;
         b_ff         <= B_RESET;
         c_ff         <= C_RESET;
         d_ff         <= D_RESET;
         th_ff        <= TH_RESET;
         v_ff         <= V_RESET;
         u_ff         <= U_RESET;
         i_ff         <= '0;
         spike_ff     <= 1'b0;
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         th_ff        <= th_in;
         v_ff         <= v_in;
         u_ff         <= u_in;
         i_ff         <= i_in;
         spike_ff     <= spike_in;
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      deriv_ff    <= deriv_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // assertions
   `IZN_ASSERT_NEXT(a_integrate_start, clock, reset,
      req_accept && (in_mode == MODE_INTEGRATE), state_ff == ST_MUL_KV,
      "integrate transaction did not start the multiply sequence")
   `IZN_ASSERT_IMPL(a_voltage_bound, clock, reset,
      1'b1, (v32 <= SAT_LIM) && (v32 >= -SAT_LIM),
      "membrane voltage outside the saturation range")
   `IZN_ASSERT_IMPL(a_spike_change, clock, reset,
      !$stable(spike_ff), $past(req_accept && (in_mode == MODE_FIRE)),
      "spike flag changed without a firing transaction")
   `IZN_ASSERT_IMPL(a_result_source, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == ST_DONE),
      "result raised outside the completion state")

endmodule

// File: design/izn_mul.sv
// ---------------------------------------------------------------------------
// izhikevich neuron shared multiplier
// signed multiply with the full product held in a register
// ---------------------------------------------------------------------------
module izn_mul (
   input  logic               clock,
   input  logic               mul_en,
   input  izn_pkg::mul_op_type   op_a,
   input  izn_pkg::mul_op_type   op_b,
   output izn_pkg::mul_prod_type prod
);
   import izn_pkg::*;

   mul_prod_type prod_ff;
   mul_prod_type prod_in;

   // product, extended to full width before multiplying
   assign prod_in = mul_prod_type'(op_a) * mul_prod_type'(op_b);

   // product register, loaded only when the sequencer asks
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
